[rtl/core/v3a_pkg.sv]
// ----------------------------------------------------------------------------
// v3a_pkg
// Shared constants, opcodes, lane result type and saturation helpers for the
// three-component vector ALU.
// ----------------------------------------------------------------------------
package v3a_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int LANES         = 3;

    // square root: one result bit per stage plus a rounding stage
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;

    // divider: input capture plus one quotient bit per stage
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 1;

    // opcodes
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_SCALE  = 3'd2;
    localparam logic [2:0] OP_DOT    = 3'd3;
    localparam logic [2:0] OP_LEN    = 3'd4;
    localparam logic [2:0] OP_NORM   = 3'd5;
    localparam logic [2:0] OP_COS    = 3'd6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // what one lane finds for one component
    typedef struct packed {
        logic [31:0] sum_v;
        logic [31:0] dif_v;
        logic [63:0] p_ab;
        logic [63:0] p_aa;
        logic [63:0] p_bb;
        logic [63:0] p_as;
        logic        n_ab;
        logic        n_as;
        logic [31:0] a_mag;
        logic        a_neg;
    } t_lane;

    // magnitude of a two's complement word
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // saturate a 33-bit sum to 32 bits
    function automatic logic [31:0] sat_add(input logic [32:0] s);
        if (s[32] != s[31]) begin
            return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    // sign-magnitude to saturated two's complement; big means mag >= 2^32
    function automatic logic [31:0] sat_sm(input logic neg, input logic big,
                                           input logic [31:0] mag);
        if (neg) begin
            if (big || mag[31]) begin
                return 32'h8000_0000;
            end
            return ~mag + 32'd1;
        end
        if (big || mag[31]) begin
            return 32'h7FFF_FFFF;
        end
        return mag;
    endfunction

endpackage

[rtl/core/v3a_lane.sv]
// ----------------------------------------------------------------------------
// v3a_lane
// One component lane: saturated add and subtract, and the unsigned products
// a*b, a*a, b*b and a*scale with their signs.
// ----------------------------------------------------------------------------
module v3a_lane (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    input  logic [31:0]         i_s,
    output v3a_pkg::t_lane      o_res
);

    logic [31:0]    a_m;
    logic [31:0]    b_m;
    logic [31:0]    s_m;
    v3a_pkg::t_lane r_res;

    // operand magnitudes
    always_comb begin
        a_m = v3a_pkg::mag32(i_a);
        b_m = v3a_pkg::mag32(i_b);
        s_m = v3a_pkg::mag32(i_s);
    end

    // lane register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.sum_v <= v3a_pkg::sat_add({i_a[31], i_a} + {i_b[31], i_b});
            r_res.dif_v <= v3a_pkg::sat_add({i_a[31], i_a} - {i_b[31], i_b});
            r_res.p_ab  <= a_m * b_m;
            r_res.p_aa  <= a_m * a_m;
            r_res.p_bb  <= b_m * b_m;
            r_res.p_as  <= a_m * s_m;
            r_res.n_ab  <= i_a[31] ^ i_b[31];
            r_res.n_as  <= i_a[31] ^ i_s[31];
            r_res.a_mag <= a_m;
            r_res.a_neg <= i_a[31];
        end
    end

    assign o_res = r_res;

endmodule

[rtl/core/v3a_sqrt.sv]
// ----------------------------------------------------------------------------
// v3a_sqrt
// Pipelined 64-bit integer square root, one root bit per stage, rounded to
// nearest in a final stage.
// ----------------------------------------------------------------------------
module v3a_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);

    localparam int N  = v3a_pkg::SQRT_STEPS;
    localparam int RW = 34;
    localparam int TW = RW + 2;

    logic [63:0]    r_x    [0:N-2];
    logic [RW-1:0]  r_rem  [0:N-1];
    logic [31:0]    r_root [0:N-1];
    logic [31:0]    r_out;

    // one digit step: returns {remainder, root}
    function automatic logic [RW+31:0] step(input logic [RW-1:0] rem,
                                            input logic [31:0] root,
                                            input logic [1:0] bits);
        logic [TW-1:0] t;
        logic [TW-1:0] d;
        logic [RW-1:0] nrem;
        logic [31:0]   nroot;
        t = {rem, bits};
        d = {2'b00, root, 2'b01};
        if (t >= d) begin
            nrem  = RW'(t - d);
            nroot = {root[30:0], 1'b1};
        end else begin
            nrem  = t[RW-1:0];
            nroot = {root[30:0], 1'b0};
        end
        return {nrem, nroot};
    endfunction

    // digit stages and rounding stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {r_rem[0], r_root[0]} <= step('0, '0, i_val[63:62]);
            r_x[0] <= {i_val[61:0], 2'b00};
            for (int k = 1; k < N; k++) begin
                {r_rem[k], r_root[k]} <= step(r_rem[k-1], r_root[k-1], r_x[k-1][63:62]);
            end
            for (int k = 1; k < N - 1; k++) begin
                r_x[k] <= {r_x[k-1][61:0], 2'b00};
            end
            r_out <= r_root[N-1] + 32'(r_rem[N-1] > {2'b00, r_root[N-1]});
        end
    end

    assign o_root = r_out;

endmodule

[rtl/core/v3a_div.sv]
// ----------------------------------------------------------------------------
// v3a_div
// Pipelined restoring divider: 32-bit quotient of a wide numerator by a
// 64-bit divisor, one quotient bit per stage, with an overflow flag when the
// quotient does not fit in 32 bits.
// ----------------------------------------------------------------------------
module v3a_div #(
    parameter  int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
    localparam int NUM_W     = v3a_pkg::PROD_W + FRAC_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [63:0]      i_den,
    output logic [31:0]      o_quo,
    output logic             o_ovf
);

    localparam int N   = v3a_pkg::DIV_STEPS;
    localparam int H_W = NUM_W - 32;

    logic [H_W-1:0] r_h;
    logic [31:0]    r_l;
    logic [63:0]    r_d;
    logic [63:0]    r_p  [0:N-2];
    logic [31:0]    r_q  [0:N-1];
    logic [31:0]    r_lo [0:N-2];
    logic [63:0]    r_dd [0:N-2];
    logic           r_ov [0:N-1];
    logic [63:0]    h_ext;

    // trial subtract decision
    function automatic logic sub_ok(input logic [63:0] p, input logic lb,
                                    input logic [63:0] d);
        return {p, lb} >= {1'b0, d};
    endfunction

    // next partial remainder
    function automatic logic [63:0] nxt_rem(input logic [63:0] p, input logic lb,
                                            input logic [63:0] d);
        logic [64:0] n;
        n = {p, lb};
        if (n >= {1'b0, d}) begin
            return 64'(n - {1'b0, d});
        end
        return n[63:0];
    endfunction

    assign h_ext = {{(64 - H_W){1'b0}}, r_h};

    // capture, then one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h <= i_num[NUM_W-1:32];
            r_l <= i_num[31:0];
            r_d <= i_den;

            r_ov[0] <= h_ext >= r_d;
            r_p[0]  <= nxt_rem(h_ext, r_l[31], r_d);
            r_q[0]  <= {31'b0, sub_ok(h_ext, r_l[31], r_d)};
            r_lo[0] <= {r_l[30:0], 1'b0};
            r_dd[0] <= r_d;

            for (int k = 1; k < N; k++) begin
                r_ov[k] <= r_ov[k-1];
                r_q[k]  <= {r_q[k-1][30:0], sub_ok(r_p[k-1], r_lo[k-1][31], r_dd[k-1])};
            end
            for (int k = 1; k < N - 1; k++) begin
                r_p[k]  <= nxt_rem(r_p[k-1], r_lo[k-1][31], r_dd[k-1]);
                r_lo[k] <= {r_lo[k-1][30:0], 1'b0};
                r_dd[k] <= r_dd[k-1];
            end
        end
    end

    assign o_quo = r_q[N-1];
    assign o_ovf = r_ov[N-1];

endmodule

[rtl/core/vector3_alu_core.sv]
// ----------------------------------------------------------------------------
// vector3_alu_core
// Three-component vector ALU in signed fixed point: add, sub, scale, dot,
// length, normalize and cosine, with saturation and a zero-length flag.
// Pipeline: lanes, merge, 33-stage square root, pre-divide stage, 33-stage
//   divider and output register, from an accepted transaction to o_valid.
// Throughput: one transaction per cycle; the whole pipeline holds only when a
//   finished result waits at the output and the last stage is full.
// Reset: synchronous active-low i_rst_n clears every stage valid and o_valid.
// ----------------------------------------------------------------------------
module vector3_alu_core #(
    parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_az,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_bz,
    input  logic signed [31:0] i_scale,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_rx,
    output logic signed [31:0] o_ry,
    output logic signed [31:0] o_rz,
    output logic signed [31:0] o_scalar_out,
    output logic               o_zero_divisor
);

    localparam int SL    = v3a_pkg::SQRT_LAT;
    localparam int DL    = v3a_pkg::DIV_LAT;
    localparam int LN    = v3a_pkg::LANES;
    localparam int NUM_W = v3a_pkg::PROD_W + FRAC_BITS + 1;
    localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);

    typedef struct packed {
        logic [2:0]           op;
        logic [LN-1:0][31:0]  vec;
        logic [63:0]          pos;
        logic [63:0]          ngt;
        logic [LN-1:0][31:0]  a_mag;
        logic [LN-1:0]        a_neg;
    } t_mid;

    typedef struct packed {
        logic [2:0]           op;
        logic [LN-1:0][31:0]  vec;
        logic [63:0]          m;
        logic                 m_neg;
        logic [31:0]          la;
        logic [63:0]          lab;
        logic [LN-1:0][31:0]  a_mag;
        logic [LN-1:0]        a_neg;
        logic                 zd;
    } t_pre;

    typedef struct packed {
        logic [2:0]           op;
        logic [LN-1:0][31:0]  vec;
        logic [31:0]          sc;
        logic [LN-1:0]        neg;
        logic                 zd;
    } t_tail;

    // valid chain and flow control
    logic           adv;
    logic           r_v1;
    logic           r_v2;
    logic [SL-1:0]  r_v2d;
    logic           r_v3;
    logic [DL-1:0]  r_v4;
    logic           r_ovalid;
    logic [2:0]     r_op1;

    // lanes
    logic [LN-1:0][31:0] va;
    logic [LN-1:0][31:0] vb;
    v3a_pkg::t_lane      lane_q [0:LN-1];

    // merge stage
    t_mid        n_mid;
    t_mid        r_mid;
    logic [63:0] n_saa;
    logic [63:0] n_sbb;
    logic [63:0] r_saa;
    logic [63:0] r_sbb;
    logic [63:0] t_sc;
    logic [63:0] rs_sc;
    t_mid        r_midd [0:SL-1];

    // lengths and pre-divide stage
    logic [31:0] la_w;
    logic [31:0] lb_w;
    t_pre        n_pre;
    t_pre        r_pre;

    // divide stage
    t_tail            n_tail;
    t_tail            r_tail [0:DL-1];
    logic [64:0]      t_dot;
    logic [64:0]      rd_dot;
    logic [NUM_W-1:0] div_num [0:LN-1];
    logic [63:0]      div_den [0:LN-1];
    logic [31:0]      quo     [0:LN-1];
    logic             ovf     [0:LN-1];

    // output stage
    logic [LN-1:0][31:0] n_vec;
    logic [31:0]         n_sc;
    logic                n_zd;
    logic [LN-1:0][31:0] r_vec;
    logic [31:0]         r_sc;
    logic                r_zd;

    // pipeline moves unless a finished result is blocked at the output
    assign adv     = !(r_ovalid && i_stall && r_v4[DL-1]);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v2d    <= '0;
            r_v3     <= 1'b0;
            r_v4     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_v1  <= i_valid;
                r_v2  <= r_v1;
                r_v2d <= {r_v2d[SL-2:0], r_v2};
                r_v3  <= r_v2d[SL-1];
                r_v4  <= {r_v4[DL-2:0], r_v3};
            end
            if (adv && r_v4[DL-1]) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // component lanes
    assign va[0] = i_ax;
    assign va[1] = i_ay;
    assign va[2] = i_az;
    assign vb[0] = i_bx;
    assign vb[1] = i_by;
    assign vb[2] = i_bz;

    for (genvar g = 0; g < LN; g++) begin : g_lane
        v3a_lane u_lane (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_a   (va[g]),
            .i_b   (vb[g]),
            .i_s   (i_scale),
            .o_res (lane_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_op1 <= i_op;
        end
    end

    // merge: dot sums, squared lengths and the simple vector results
    always_comb begin
        n_mid     = '0;
        n_mid.op  = r_op1;
        n_saa     = '0;
        n_sbb     = '0;
        t_sc      = '0;
        rs_sc     = '0;
        for (int i = 0; i < LN; i++) begin
            if (lane_q[i].n_ab) begin
                n_mid.ngt = n_mid.ngt + lane_q[i].p_ab;
            end else begin
                n_mid.pos = n_mid.pos + lane_q[i].p_ab;
            end
            n_saa = n_saa + lane_q[i].p_aa;
            n_sbb = n_sbb + lane_q[i].p_bb;
            n_mid.a_mag[i] = lane_q[i].a_mag;
            n_mid.a_neg[i] = lane_q[i].a_neg;
            t_sc  = lane_q[i].p_as + HALF_LSB;
            rs_sc = t_sc >> FRAC_BITS;
            case (r_op1)
                v3a_pkg::OP_ADD:   n_mid.vec[i] = lane_q[i].sum_v;
                v3a_pkg::OP_SUB:   n_mid.vec[i] = lane_q[i].dif_v;
                v3a_pkg::OP_SCALE: n_mid.vec[i] = v3a_pkg::sat_sm(lane_q[i].n_as,
                                                  |rs_sc[63:32], rs_sc[31:0]);
                default:           n_mid.vec[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mid <= n_mid;
            r_saa <= n_saa;
            r_sbb <= n_sbb;
            r_midd[0] <= r_mid;
            for (int k = 1; k < SL; k++) begin
                r_midd[k] <= r_midd[k-1];
            end
        end
    end

    // lengths of a and b
    v3a_sqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  (r_saa),
        .o_root (la_w)
    );

    v3a_sqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  (r_sbb),
        .o_root (lb_w)
    );

    // pre-divide: dot magnitude, product of lengths, zero-length check
    always_comb begin
        n_pre       = '0;
        n_pre.op    = r_midd[SL-1].op;
        n_pre.vec   = r_midd[SL-1].vec;
        n_pre.a_mag = r_midd[SL-1].a_mag;
        n_pre.a_neg = r_midd[SL-1].a_neg;
        if (r_midd[SL-1].pos >= r_midd[SL-1].ngt) begin
            n_pre.m     = r_midd[SL-1].pos - r_midd[SL-1].ngt;
            n_pre.m_neg = 1'b0;
        end else begin
            n_pre.m     = r_midd[SL-1].ngt - r_midd[SL-1].pos;
            n_pre.m_neg = 1'b1;
        end
        n_pre.la  = la_w;
        n_pre.lab = la_w * lb_w;
        n_pre.zd  = ((r_midd[SL-1].op == v3a_pkg::OP_NORM) && (la_w == '0)) ||
                    ((r_midd[SL-1].op == v3a_pkg::OP_COS) &&
                     ((la_w == '0) || (lb_w == '0)));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pre <= n_pre;
        end
    end

    // scalar results and divider operands
    always_comb begin
        n_tail     = '0;
        n_tail.op  = r_pre.op;
        n_tail.vec = r_pre.vec;
        n_tail.zd  = r_pre.zd;
        t_dot  = {1'b0, r_pre.m} + {1'b0, HALF_LSB};
        rd_dot = t_dot >> FRAC_BITS;
        case (r_pre.op)
            v3a_pkg::OP_DOT: n_tail.sc = v3a_pkg::sat_sm(r_pre.m_neg, |rd_dot[64:32],
                                                         rd_dot[31:0]);
            v3a_pkg::OP_LEN: n_tail.sc = v3a_pkg::sat_sm(1'b0, 1'b0, r_pre.la);
            default:         n_tail.sc = '0;
        endcase
        for (int i = 0; i < LN; i++) begin
            n_tail.neg[i] = r_pre.a_neg[i];
            div_num[i] = (NUM_W'(r_pre.a_mag[i]) << FRAC_BITS) + NUM_W'(r_pre.la >> 1);
            div_den[i] = 64'(r_pre.la);
        end
        if (r_pre.op == v3a_pkg::OP_COS) begin
            n_tail.neg[0] = r_pre.m_neg;
            div_num[0] = (NUM_W'(r_pre.m) << FRAC_BITS) + NUM_W'(r_pre.lab >> 1);
            div_den[0] = r_pre.lab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tail[0] <= n_tail;
            for (int k = 1; k < DL; k++) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    for (genvar g = 0; g < LN; g++) begin : g_div
        v3a_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (div_num[g]),
            .i_den (div_den[g]),
            .o_quo (quo[g]),
            .o_ovf (ovf[g])
        );
    end

    // final selection
    always_comb begin
        n_vec = r_tail[DL-1].vec;
        n_sc  = r_tail[DL-1].sc;
        n_zd  = r_tail[DL-1].zd;
        if (r_tail[DL-1].zd) begin
            n_vec = '0;
            n_sc  = '0;
        end else begin
            case (r_tail[DL-1].op)
                v3a_pkg::OP_NORM: begin
                    for (int i = 0; i < LN; i++) begin
                        n_vec[i] = v3a_pkg::sat_sm(r_tail[DL-1].neg[i], ovf[i], quo[i]);
                    end
                    n_sc = '0;
                end
                v3a_pkg::OP_COS: begin
                    n_vec = '0;
                    n_sc  = v3a_pkg::sat_sm(r_tail[DL-1].neg[0], ovf[0], quo[0]);
                end
                default: begin
                    n_vec = r_tail[DL-1].vec;
                    n_sc  = r_tail[DL-1].sc;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (adv && r_v4[DL-1]) begin
            r_vec <= n_vec;
            r_sc  <= n_sc;
            r_zd  <= n_zd;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_rx           = r_vec[0];
    assign o_ry           = r_vec[1];
    assign o_rz           = r_vec[2];
    assign o_scalar_out   = r_sc;
    assign o_zero_divisor = r_zd;

    // checks
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid set after reset");

    a_zd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_divisor) |->
        (o_rx == 0 && o_ry == 0 && o_rz == 0 && o_scalar_out == 0))
        else $error("zero-length result carries nonzero data");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_v4[DL-1]) |=> !o_valid)
        else $error("result repeated after being taken");

endmodule
